/* rtl/core/tftpc_pkg.sv */
// ----------------------------------------------------------------------------
// TFTP client package
// Shared types, codes and constants of the stop-and-wait TFTP client.
// ----------------------------------------------------------------------------
package tftpc_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned LEN_W       = 10;
  localparam int unsigned BLK_W       = 16;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned TICK_W      = 16;
  localparam int unsigned RETRY_W     = 4;

  localparam logic [TICK_W-1:0]  TIMEOUT_RST = 16'd100;
  localparam logic [RETRY_W-1:0] RETRY_RST   = 4'd5;

  // Result queue depth; an item may push up to three results.
  localparam int unsigned QDEPTH  = 8;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = QPTR_W + 1;
  localparam int unsigned MAX_RES = 3;

  localparam int unsigned PADDR_W = 3;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_TIMEOUT = 1'b0,
    REG_RETRY   = 1'b1
  } reg_idx_t;

  // Input commands.
  typedef enum logic [2:0] {
    CMD_START_WRITE = 3'd0,
    CMD_START_READ  = 3'd1,
    CMD_TICK        = 3'd2,
    CMD_PACKET      = 3'd3,
    CMD_LOADED      = 3'd4
  } cmd_t;

  // TFTP packet opcodes.
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_RRQ  = 3'd1,
    OP_WRQ  = 3'd2,
    OP_DATA = 3'd3,
    OP_ACK  = 3'd4,
    OP_ERR  = 3'd5
  } tftp_op_t;

  // Result actions.
  typedef enum logic [2:0] {
    ACT_REQ   = 3'd0,
    ACT_DATA  = 3'd1,
    ACT_ACK   = 3'd2,
    ACT_WRITE = 3'd3,
    ACT_LOAD  = 3'd4,
    ACT_DONE  = 3'd5,
    ACT_FAIL  = 3'd6
  } act_t;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_REQ       = 5'b00010,
    PH_LOAD      = 5'b00100,
    PH_WAIT_ACK  = 5'b01000,
    PH_WAIT_DATA = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0]  timeout_ticks;
    logic [RETRY_W-1:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic               transfer_mode;
    logic [2:0]         packet_kind;
    logic [BLK_W-1:0]   block_number;
    logic [LEN_W-1:0]   length;
  } item_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [2:0]         packet_opcode;
    logic [BLK_W-1:0]   block;
    logic [LEN_W-1:0]   byte_count;
    logic               mode_echo;
    logic [TOTAL_W-1:0] bytes_moved;
    logic               last;
  } res_t;

  function automatic res_t mk_res(act_t act, tftp_op_t op, logic [BLK_W-1:0] blk,
                                  logic [LEN_W-1:0] cnt, logic mode,
                                  logic [TOTAL_W-1:0] bytes);
    res_t r;
    r.action        = act;
    r.packet_opcode = op;
    r.block         = blk;
    r.byte_count    = cnt;
    r.mode_echo     = mode;
    r.bytes_moved   = bytes;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/core/tftpc_cfg.sv */
// ----------------------------------------------------------------------------
// TFTP client configuration registers
// APB-style register file holding the timeout and the retry limit.
// ----------------------------------------------------------------------------
module tftpc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tftpc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output tftpc_pkg::cfg_t                cfg
);
  import tftpc_pkg::*;

  logic [TICK_W-1:0]  timeout_ticks;
  logic [RETRY_W-1:0] retry_limit;
  logic               wr_en;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RST;
      retry_limit   <= RETRY_RST;
    end else if (wr_en) begin
      case (idx)
        REG_TIMEOUT: timeout_ticks <= pwdata[TICK_W-1:0];
        REG_RETRY:   retry_limit   <= pwdata[RETRY_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TIMEOUT: prdata = {{(32-TICK_W){1'b0}}, timeout_ticks};
      REG_RETRY:   prdata = {{(32-RETRY_W){1'b0}}, retry_limit};
      default:     prdata = '0;
    endcase
  end

  assign cfg.timeout_ticks = timeout_ticks;
  assign cfg.retry_limit   = retry_limit;

endmodule

/* rtl/core/tftpc_ctrl.sv */
// ----------------------------------------------------------------------------
// TFTP client transfer controller
// Holds the transfer state and turns one accepted item into up to three
// results combinationally, in the cycle the item is accepted.
// ----------------------------------------------------------------------------
module tftpc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  tftpc_pkg::cfg_t       cfg,
  input  logic                  item_valid,
  input  tftpc_pkg::item_t      item,
  output logic [1:0]            res_num,
  output tftpc_pkg::res_t       res [tftpc_pkg::MAX_RES]
);
  import tftpc_pkg::*;

  phase_t              phase, phase_next;
  logic                is_download, is_download_next;
  logic                mode_bit, mode_bit_next;
  logic [BLK_W-1:0]    current_block, current_block_next;
  logic [LEN_W-1:0]    last_length, last_length_next;
  logic [TICK_W-1:0]   tick_count, tick_count_next;
  logic [RETRY_W-1:0]  retry_count, retry_count_next;
  logic [TOTAL_W-1:0]  byte_total, byte_total_next;

  logic [LEN_W-1:0]    len;
  logic [TICK_W:0]     tick_inc;
  logic [BLK_W-1:0]    block_inc;
  logic [TOTAL_W:0]    sum;
  logic [TOTAL_W-1:0]  total_add;
  logic                timed_out;
  logic                ack_ok;
  logic                data_ok;
  res_t                resend_res;

  assign len = (item.length > LEN_W'(BLOCK_BYTES)) ? LEN_W'(BLOCK_BYTES) : item.length;
  assign tick_inc  = {1'b0, tick_count} + 1'b1;
  assign timed_out = tick_inc >= {1'b0, cfg.timeout_ticks};
  assign block_inc = current_block + 1'b1;
  assign sum       = {1'b0, byte_total} + {{(TOTAL_W+1-LEN_W){1'b0}}, len};
  assign total_add = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

  assign ack_ok = !is_download && (phase == PH_REQ || phase == PH_WAIT_ACK) &&
                  item.packet_kind == OP_ACK && item.block_number == current_block;
  assign data_ok = is_download && (phase == PH_REQ || phase == PH_WAIT_DATA) &&
                   item.packet_kind == OP_DATA && item.block_number == block_inc;

  always_comb begin
    case (phase)
      PH_REQ:      resend_res = mk_res(ACT_REQ, is_download ? OP_RRQ : OP_WRQ, '0, '0,
                                       mode_bit, '0);
      PH_WAIT_ACK: resend_res = mk_res(ACT_DATA, OP_DATA, current_block, last_length,
                                       1'b0, '0);
      default:     resend_res = mk_res(ACT_ACK, OP_ACK, current_block, '0, 1'b0, '0);
    endcase
  end

  always_comb begin
    phase_next         = phase;
    is_download_next   = is_download;
    mode_bit_next      = mode_bit;
    current_block_next = current_block;
    last_length_next   = last_length;
    tick_count_next    = tick_count;
    retry_count_next   = retry_count;
    byte_total_next    = byte_total;
    res_num            = 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end

    if (item_valid) begin
      case (item.opcode)
        CMD_START_WRITE, CMD_START_READ: begin
          if (phase == PH_IDLE) begin
            is_download_next   = item.opcode[0];
            mode_bit_next      = item.transfer_mode;
            current_block_next = '0;
            last_length_next   = '0;
            byte_total_next    = '0;
            tick_count_next    = '0;
            retry_count_next   = RETRY_W'(1);
            phase_next         = PH_REQ;
            res[0]  = mk_res(ACT_REQ, item.opcode[0] ? OP_RRQ : OP_WRQ, '0, '0,
                             item.transfer_mode, '0);
            res_num = 2'd1;
          end
        end
        CMD_TICK: begin
          if (phase == PH_REQ || phase == PH_WAIT_ACK || phase == PH_WAIT_DATA) begin
            if (timed_out) begin
              tick_count_next = '0;
              if (retry_count >= cfg.retry_limit) begin
                phase_next = PH_IDLE;
                res[0] = mk_res(ACT_FAIL, OP_NONE, '0, '0, 1'b0, byte_total);
              end else begin
                retry_count_next = retry_count + 1'b1;
                res[0] = resend_res;
              end
              res_num = 2'd1;
            end else begin
              tick_count_next = tick_inc[TICK_W-1:0];
            end
          end
        end
        CMD_PACKET: begin
          if (ack_ok) begin
            // A short DATA block that is acknowledged ends an upload.
            if (phase == PH_WAIT_ACK && last_length < LEN_W'(BLOCK_BYTES)) begin
              phase_next = PH_IDLE;
              res[0] = mk_res(ACT_DONE, OP_NONE, '0, '0, 1'b0, byte_total);
            end else begin
              current_block_next = block_inc;
              phase_next         = PH_LOAD;
              res[0] = mk_res(ACT_LOAD, OP_NONE, block_inc, '0, 1'b0, '0);
            end
            res_num = 2'd1;
          end else if (data_ok) begin
            current_block_next = item.block_number;
            last_length_next   = len;
            byte_total_next    = total_add;
            res[0] = mk_res(ACT_WRITE, OP_NONE, item.block_number, len, 1'b0, '0);
            res[1] = mk_res(ACT_ACK, OP_ACK, item.block_number, '0, 1'b0, '0);
            if (len < LEN_W'(BLOCK_BYTES)) begin
              phase_next = PH_IDLE;
              res[2]  = mk_res(ACT_DONE, OP_NONE, '0, '0, 1'b0, total_add);
              res_num = 2'd3;
            end else begin
              phase_next       = PH_WAIT_DATA;
              tick_count_next  = '0;
              retry_count_next = RETRY_W'(1);
              res_num          = 2'd2;
            end
          end
        end
        CMD_LOADED: begin
          if (phase == PH_LOAD) begin
            last_length_next = len;
            byte_total_next  = total_add;
            phase_next       = PH_WAIT_ACK;
            tick_count_next  = '0;
            retry_count_next = RETRY_W'(1);
            res[0]  = mk_res(ACT_DATA, OP_DATA, current_block, len, 1'b0, '0);
            res_num = 2'd1;
          end
        end
        default: ;
      endcase
    end

    case (res_num)
      2'd1:    res[0].last = 1'b1;
      2'd2:    res[1].last = 1'b1;
      2'd3:    res[2].last = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      is_download   <= 1'b0;
      mode_bit      <= 1'b0;
      current_block <= '0;
      last_length   <= '0;
      tick_count    <= '0;
      retry_count   <= '0;
      byte_total    <= '0;
    end else begin
      phase         <= phase_next;
      is_download   <= is_download_next;
      mode_bit      <= mode_bit_next;
      current_block <= current_block_next;
      last_length   <= last_length_next;
      tick_count    <= tick_count_next;
      retry_count   <= retry_count_next;
      byte_total    <= byte_total_next;
    end
  end

endmodule

/* rtl/core/tftpc_rq.sv */
// ----------------------------------------------------------------------------
// TFTP client result queue
// Small queue that takes up to three results a cycle and hands out one while out_ready is high.
// ----------------------------------------------------------------------------
module tftpc_rq (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [1:0]                         push_num,
  input  tftpc_pkg::res_t                    push_res [tftpc_pkg::MAX_RES],
  output logic                               room,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tftpc_pkg::res_t                    out_res
);
  import tftpc_pkg::*;

  res_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign out_res   = mem[rd_ptr];
  // Room for the worst case of one item.
  assign room      = count <= QCNT_W'(QDEPTH - MAX_RES);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (QCNT_W'(i) < {{(QCNT_W-2){1'b0}}, push_num}) begin
        mem[wr_ptr + QPTR_W'(i)] <= push_res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_num);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(push_num) - QCNT_W'(pop);
    end
  end

endmodule

/* rtl/core/tftp_stop_and_wait_client.sv */
// ----------------------------------------------------------------------------
// TFTP stop-and-wait client
// Lock-step TFTP client controller with timeout, retries and byte totals.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  s_*      in         commands, ticks, packet headers, block-loaded notices
//  m_*      out        actions: send request/DATA/ACK, write, load, done, failed
//  apb      in/out     timeout_ticks at 0x0, retry_limit at 0x4
//
// An item is handled in the cycle its transfer is taken and its results
// enter a queue of eight entries; the first result is offered on the next
// cycle, one per cycle while m_tready is high. s_tready is high while the
// queue has room for three results, so single-result items then flow at
// one per cycle. Reset is synchronous and clears transfer state and queue.
module tftp_stop_and_wait_client (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // transfer_mode[0], packet_kind[3:1], block_number[19:4], length[29:20]
  input  logic [31:0]                   s_tdata,
  // opcode[2:0]
  input  logic [2:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // packet_opcode[2:0], block[18:3], byte_count[28:19], mode_echo[29],
  // bytes_moved[61:30]
  output logic [63:0]                   m_tdata,
  // action[2:0]
  output logic [2:0]                    m_tuser,
  output logic                          m_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tftpc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tftpc_pkg::*;

  cfg_t       cfg;
  item_t      item;
  logic       item_valid;
  logic [1:0] res_num;
  res_t       res [MAX_RES];
  res_t       out_res;
  logic       room;

  assign s_tready   = room;
  assign item_valid = s_tvalid && s_tready;

  assign item.opcode        = s_tuser;
  assign item.transfer_mode = s_tdata[0];
  assign item.packet_kind   = s_tdata[3:1];
  assign item.block_number  = s_tdata[19:4];
  assign item.length        = s_tdata[29:20];

  tftpc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tftpc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .res_num    (res_num),
    .res        (res)
  );

  tftpc_rq u_rq (
    .clk       (clk),
    .rst       (rst),
    .push_num  (res_num),
    .push_res  (res),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tuser = out_res.action;
  assign m_tlast = out_res.last;
  assign m_tdata = {2'b00, out_res.bytes_moved, out_res.mode_echo, out_res.byte_count,
                    out_res.block, out_res.packet_opcode};

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TFTP stop-and-wait client testbench
// Drives commands, ticks, packet headers and block-loaded notices into the
// client under random source and sink stalls. A cycle-free model of the
// client predicts every action, and each output transfer is checked against
// the oldest prediction field by field. Registers are changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import tftpc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // transfer_mode[0], packet_kind[3:1], block_number[19:4], length[29:20]
  logic [31:0] s_tdata = '0;
  // opcode[2:0]
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // packet_opcode[2:0], block[18:3], byte_count[28:19], mode_echo[29],
  // bytes_moved[61:30]
  logic [63:0] m_tdata;
  // action[2:0]
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tftp_stop_and_wait_client DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Client model state and its copy of the registers.
  phase_t             ph;
  logic               downloading;
  logic               req_mode;
  logic [BLK_W-1:0]   cur_blk;
  logic [LEN_W-1:0]   held_len;
  logic [TICK_W-1:0]  tick_cnt;
  logic [RETRY_W-1:0] tries;
  logic [TOTAL_W-1:0] total_bytes;
  logic [TICK_W-1:0]  tmo;
  logic [RETRY_W-1:0] try_limit;

  item_t       cmd_queue[$];
  res_t        expected_actions[$];
  item_t       drv_item;
  item_t       seen_item;
  res_t        want_res;

  int unsigned cmds_issued = 0;
  int unsigned cmds_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned done_seen = 0;
  int unsigned fail_seen = 0;
  int unsigned settings_used = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned src_wait = 0;
  int unsigned src_run = 0;
  int unsigned sink_wait = 0;
  int unsigned sink_run = 0;
  int unsigned sink_next;

  logic [15:0] tmo_plan [6] = '{16'd3, 16'd1, 16'd0, 16'd7, 16'hFFFF, 16'd2};
  logic [3:0]  retry_plan [6] = '{4'd3, 4'd15, 4'd0, 4'd1, 4'd4, 4'd5};

  // Wait before the next transfer; now and then a run of items with no wait.
  function automatic int unsigned draw_wait(inout int unsigned run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run = $urandom_range(4, 24);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic void push_action(act_t act, tftp_op_t op, logic [BLK_W-1:0] blk,
                                      logic [LEN_W-1:0] cnt, logic mode,
                                      logic [TOTAL_W-1:0] bytes);
    res_t r;
    r.action        = act;
    r.packet_opcode = op;
    r.block         = blk;
    r.byte_count    = cnt;
    r.mode_echo     = mode;
    r.bytes_moved   = bytes;
    r.last          = 1'b0;
    expected_actions.push_back(r);
  endfunction

  function automatic void add_total(logic [LEN_W-1:0] len);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, total_bytes} + (TOTAL_W+1)'(len);
    total_bytes = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
  endfunction

  // Works out the actions that one command causes and queues them.
  function automatic void predict_actions(item_t it);
    logic [LEN_W-1:0]  len;
    logic [TICK_W:0]   next_tick;
    int unsigned       n;
    res_t              tail;
    n = expected_actions.size();
    len = (it.length > BLOCK_BYTES) ? LEN_W'(BLOCK_BYTES) : it.length;
    case (it.opcode)
      CMD_START_WRITE, CMD_START_READ: begin
        if (ph == PH_IDLE) begin
          downloading = (it.opcode == CMD_START_READ);
          req_mode    = it.transfer_mode;
          cur_blk     = '0;
          held_len    = '0;
          total_bytes = '0;
          tick_cnt    = '0;
          tries       = 4'd1;
          ph          = PH_REQ;
          push_action(ACT_REQ, downloading ? OP_RRQ : OP_WRQ, '0, '0, req_mode, '0);
        end
      end
      CMD_TICK: begin
        if (ph == PH_REQ || ph == PH_WAIT_ACK || ph == PH_WAIT_DATA) begin
          next_tick = {1'b0, tick_cnt} + 1'b1;
          if (next_tick >= {1'b0, tmo}) begin
            tick_cnt = '0;
            if (tries >= try_limit) begin
              ph = PH_IDLE;
              push_action(ACT_FAIL, OP_NONE, '0, '0, 1'b0, total_bytes);
            end else begin
              tries = tries + 4'd1;
              // Resend whatever went out last.
              if (ph == PH_REQ)
                push_action(ACT_REQ, downloading ? OP_RRQ : OP_WRQ, '0, '0, req_mode, '0);
              else if (ph == PH_WAIT_ACK)
                push_action(ACT_DATA, OP_DATA, cur_blk, held_len, 1'b0, '0);
              else
                push_action(ACT_ACK, OP_ACK, cur_blk, '0, 1'b0, '0);
            end
          end else begin
            tick_cnt = next_tick[TICK_W-1:0];
          end
        end
      end
      CMD_PACKET: begin
        if (!downloading && (ph == PH_REQ || ph == PH_WAIT_ACK) &&
            it.packet_kind == OP_ACK && it.block_number == cur_blk) begin
          if (ph == PH_WAIT_ACK && held_len < BLOCK_BYTES) begin
            ph = PH_IDLE;
            push_action(ACT_DONE, OP_NONE, '0, '0, 1'b0, total_bytes);
          end else begin
            cur_blk = cur_blk + 16'd1;
            ph = PH_LOAD;
            push_action(ACT_LOAD, OP_NONE, cur_blk, '0, 1'b0, '0);
          end
        end else if (downloading && (ph == PH_REQ || ph == PH_WAIT_DATA) &&
                     it.packet_kind == OP_DATA &&
                     it.block_number == BLK_W'(cur_blk + 16'd1)) begin
          cur_blk  = it.block_number;
          held_len = len;
          add_total(len);
          push_action(ACT_WRITE, OP_NONE, cur_blk, len, 1'b0, '0);
          push_action(ACT_ACK, OP_ACK, cur_blk, '0, 1'b0, '0);
          if (len < BLOCK_BYTES) begin
            ph = PH_IDLE;
            push_action(ACT_DONE, OP_NONE, '0, '0, 1'b0, total_bytes);
          end else begin
            ph       = PH_WAIT_DATA;
            tick_cnt = '0;
            tries    = 4'd1;
          end
        end
      end
      CMD_LOADED: begin
        if (ph == PH_LOAD) begin
          held_len = len;
          add_total(len);
          ph       = PH_WAIT_ACK;
          tick_cnt = '0;
          tries    = 4'd1;
          push_action(ACT_DATA, OP_DATA, cur_blk, len, 1'b0, '0);
        end
      end
      default: ;
    endcase
    if (expected_actions.size() > n) begin
      tail = expected_actions.pop_back();
      tail.last = 1'b1;
      expected_actions.push_back(tail);
    end
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Source side: one command per transfer, with a random wait after each.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait = 0;
    end else if (!s_tvalid || s_tready) begin
      if (src_wait > 0) begin
        src_wait--;
        s_tvalid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        drv_item = cmd_queue.pop_front();
        s_tdata  <= {2'b00, drv_item.length, drv_item.block_number,
                     drv_item.packet_kind, drv_item.transfer_mode};
        s_tuser  <= drv_item.opcode;
        s_tvalid <= 1'b1;
        src_wait = draw_wait(src_run);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: after each transfer, ready may drop for a random wait.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      sink_next = (m_tvalid && m_tready) ? draw_wait(sink_run) : sink_wait;
      if (sink_next > 0) begin
        m_tready <= 1'b0;
        sink_wait = sink_next - 1;
      end else begin
        m_tready <= 1'b1;
        sink_wait = 0;
      end
    end
  end

  // Checks output transfers, predicts on input transfers, tracks register
  // writes and watches for a stall.
  always @(posedge clk) begin
    if (rst) begin
      tmo         = TIMEOUT_RST;
      try_limit   = RETRY_RST;
      ph          = PH_IDLE;
      downloading = 1'b0;
      req_mode    = 1'b0;
      cur_blk     = '0;
      held_len    = '0;
      tick_cnt    = '0;
      tries       = '0;
      total_bytes = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (m_tuser == ACT_DONE) done_seen++;
        if (m_tuser == ACT_FAIL) fail_seen++;
        if (expected_actions.size() == 0) begin
          $error("unexpected result: action %0d block %0d", m_tuser, m_tdata[18:3]);
          mismatches++;
        end else begin
          want_res = expected_actions.pop_front();
          check_field("action", want_res.action, m_tuser);
          check_field("packet_opcode", want_res.packet_opcode, m_tdata[2:0]);
          check_field("block", want_res.block, m_tdata[18:3]);
          check_field("byte_count", want_res.byte_count, m_tdata[28:19]);
          check_field("mode_echo", want_res.mode_echo, m_tdata[29]);
          check_field("bytes_moved", want_res.bytes_moved, m_tdata[61:30]);
          check_field("last", want_res.last, m_tlast);
        end
      end
      if (s_tvalid && s_tready) begin
        seen_item.opcode        = s_tuser;
        seen_item.transfer_mode = s_tdata[0];
        seen_item.packet_kind   = s_tdata[3:1];
        seen_item.block_number  = s_tdata[19:4];
        seen_item.length        = s_tdata[29:20];
        predict_actions(seen_item);
        cmds_accepted++;
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_TIMEOUT, 2'b00})
          tmo = pwdata[TICK_W-1:0];
        else if (paddr == {REG_RETRY, 2'b00})
          try_limit = pwdata[RETRY_W-1:0];
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_actions.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read(reg_idx_t idx, logic [31:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field(idx == REG_TIMEOUT ? "timeout_ticks" : "retry_limit", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] ticks, logic [3:0] limit);
    reg_write(REG_TIMEOUT, {16'd0, ticks});
    reg_write(REG_RETRY, {28'd0, limit});
    reg_read(REG_TIMEOUT, {16'd0, ticks});
    reg_read(REG_RETRY, {28'd0, limit});
    settings_used++;
  endtask

  // Waits until every command is taken and every action has come out.
  task automatic wait_idle();
    @(posedge clk);
    while (cmds_accepted != cmds_issued || expected_actions.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void push_cmd(logic [2:0] op, logic mode, logic [2:0] kind,
                                   logic [BLK_W-1:0] bnum, logic [LEN_W-1:0] len);
    item_t it;
    it.opcode        = op;
    it.transfer_mode = mode;
    it.packet_kind   = kind;
    it.block_number  = bnum;
    it.length        = len;
    cmd_queue.push_back(it);
    cmds_issued++;
  endfunction

  function automatic void noise_item();
    push_cmd(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
             3'($urandom_range(0, 7)), 16'($urandom()), 10'($urandom_range(0, 1023)));
  endfunction

  function automatic void maybe_ticks();
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 12)) push_cmd(CMD_TICK, 1'b0, OP_NONE, '0, '0);
  endfunction

  function automatic void maybe_noise();
    if ($urandom_range(0, 7) == 0) noise_item();
  endfunction

  // A full block, now and then with a length past the block size.
  function automatic logic [LEN_W-1:0] full_len();
    if ($urandom_range(0, 5) == 0) return 10'($urandom_range(513, 1023));
    return 10'd512;
  endfunction

  // Mostly well-formed uploads and downloads with random sizes, retries and
  // stale packets, mixed with random commands.
  task automatic random_phase(int unsigned n_items);
    int unsigned first;
    int unsigned blocks;
    int unsigned b;
    first = cmds_issued;
    while (cmds_issued - first < n_items) begin
      blocks = $urandom_range(0, 4);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          push_cmd(CMD_START_WRITE, 1'($urandom_range(0, 1)), OP_NONE, '0, '0);
          maybe_ticks();
          push_cmd(CMD_PACKET, 1'b0, OP_ACK, '0, '0);
          for (b = 1; b <= blocks + 1; b++) begin
            maybe_noise();
            push_cmd(CMD_LOADED, 1'b0, OP_NONE, '0,
                     (b <= blocks) ? full_len() : 10'($urandom_range(0, 511)));
            maybe_ticks();
            if ($urandom_range(0, 7) == 0)
              push_cmd(CMD_PACKET, 1'b0, OP_ACK, 16'(b - 1), '0);
            push_cmd(CMD_PACKET, 1'b0, OP_ACK, 16'(b), '0);
          end
        end
        4, 5, 6, 7: begin
          push_cmd(CMD_START_READ, 1'($urandom_range(0, 1)), OP_NONE, '0, '0);
          for (b = 1; b <= blocks + 1; b++) begin
            maybe_ticks();
            if ($urandom_range(0, 7) == 0)
              push_cmd(CMD_PACKET, 1'b0, OP_DATA, 16'(b - 1), 10'd512);
            maybe_noise();
            push_cmd(CMD_PACKET, 1'b0, OP_DATA, 16'(b),
                     (b <= blocks) ? full_len() : 10'($urandom_range(0, 511)));
          end
        end
        default: repeat ($urandom_range(1, 4)) noise_item();
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    reg_read(REG_TIMEOUT, 32'(TIMEOUT_RST));
    reg_read(REG_RETRY, 32'(RETRY_RST));
    set_config(16'd2, 4'd2);

    // Upload that retries its request, clips a long block and then gives up.
    push_cmd(CMD_START_WRITE, 1'b1, OP_NONE, '0, '0);
    push_cmd(CMD_START_READ, 1'b0, OP_NONE, '0, '0);      // start while busy
    push_cmd(3'd5, 1'b1, OP_DATA, 16'hFFFF, 10'd1023);     // unknown opcodes
    push_cmd(3'd7, 1'b0, OP_ACK, '0, '0);
    push_cmd(CMD_PACKET, 1'b0, OP_ERR, '0, '0);            // error packet
    push_cmd(CMD_PACKET, 1'b0, OP_ACK, 16'd1, '0);         // wrong block
    push_cmd(CMD_TICK, 1'b0, OP_NONE, '0, '0);
    push_cmd(CMD_TICK, 1'b0, OP_NONE, '0, '0);
    push_cmd(CMD_PACKET, 1'b0, OP_ACK, 16'd0, '0);
    push_cmd(CMD_TICK, 1'b0, OP_NONE, '0, '0);             // no timeout in load
    push_cmd(CMD_LOADED, 1'b0, OP_NONE, '0, 10'd1023);
    push_cmd(CMD_PACKET, 1'b0, OP_DATA, 16'd1, 10'd512);   // DATA during upload
    push_cmd(CMD_PACKET, 1'b0, OP_ACK, 16'd1, '0);
    push_cmd(CMD_LOADED, 1'b0, OP_NONE, '0, 10'd0);
    repeat (4) push_cmd(CMD_TICK, 1'b0, OP_NONE, '0, '0);
    // Download with a skipped block and an empty final block.
    push_cmd(CMD_START_READ, 1'b0, OP_NONE, '0, '0);
    push_cmd(CMD_PACKET, 1'b0, OP_DATA, 16'd2, 10'd512);
    push_cmd(CMD_PACKET, 1'b0, OP_DATA, 16'd1, 10'd512);
    push_cmd(CMD_PACKET, 1'b0, OP_ACK, 16'd1, '0);
    push_cmd(CMD_PACKET, 1'b0, OP_DATA, 16'd2, 10'd0);
    push_cmd(CMD_LOADED, 1'b0, OP_NONE, '0, 10'd100);      // loaded while idle
    // Upload that ends on a short first block.
    push_cmd(CMD_START_WRITE, 1'b0, OP_NONE, '0, '0);
    push_cmd(CMD_PACKET, 1'b0, OP_ACK, 16'd0, '0);
    push_cmd(CMD_LOADED, 1'b0, OP_NONE, '0, 10'd300);
    push_cmd(CMD_PACKET, 1'b0, OP_ACK, 16'd1, '0);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      set_config(tmo_plan[p], retry_plan[p]);
      random_phase(60);
      wait_idle();
    end

    $display("Run covered %0d commands and %0d actions under %0d register settings.",
             cmds_accepted, results_seen, settings_used);
    $display("Sessions finished: %0d, sessions given up: %0d.",
             done_seen, fail_seen);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/tftpc_pkg.sv
rtl/core/tftpc_cfg.sv
rtl/core/tftpc_ctrl.sv
rtl/core/tftpc_rq.sv
rtl/core/tftp_stop_and_wait_client.sv
verif/tb_top.sv
